// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Types, sizes and token/status codes of the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;

   typedef logic [2:0]               kind_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [6:0]               depth_out_type;
   typedef logic [1:0]               status_type;

   localparam kind_type KIND_PUSH = 3'd0;
   localparam kind_type KIND_ADD  = 3'd1;
   localparam kind_type KIND_SUB  = 3'd2;
   localparam kind_type KIND_MUL  = 3'd3;
   localparam kind_type KIND_DIV  = 3'd4;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_UNDER   = 2'd1;
   localparam status_type ST_OVER    = 2'd2;
   localparam status_type ST_DIVZERO = 2'd3;

endpackage

// ===== hw/rtl/rpn_if.sv =====
// ----------------------------------------------------------------------------
// rpn_if
// Valid/ready channels for token requests and stack responses.
// ----------------------------------------------------------------------------
interface rpn_req_if;
   import rpn_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   data_type operand;

   modport source (output valid, output kind, output operand, input ready);
   modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface rpn_rsp_if;
   import rpn_pkg::*;

   logic          valid;
   logic          ready;
   data_type      top_value;
   data_type      bottom_value;
   depth_out_type depth;
   status_type    status;

   modport source (output valid, output top_value, output bottom_value, output depth,
                   output status, input ready);
   modport sink   (input valid, input top_value, input bottom_value, input depth,
                   input status, output ready);
endinterface

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix evaluator over a bounded stack of 32-bit signed integers.
// ----------------------------------------------------------------------------
// Usage: each req_chan transaction carries one token (push, add, subtract,
// multiply, divide) and yields exactly one rsp_chan transaction with the
// top entry, the bottom entry, the depth and a status code.
// req_chan.ready is high only while the sequencer is idle; one token is
// worked on at a time. States a token passes through when the response
// slot is free:
//   push, no-op and error tokens: finish
//   add, subtract: load, add, finish
//   multiply: load, 32 shift-add steps through the shared adder, finish
//   divide: load, 32 restoring steps through the adder, sign fix, finish
// The sequencer returns to idle as it raises rsp_chan.valid and accepts the
// next token from there.
// One 34-bit add/subtract unit serves all arithmetic; the stack lives in a
// 64-entry memory read through a registered port, with the top and bottom
// entries cached in registers.
// Reset (synchronous, active high) empties the stack and drops any pending
// response. A stalled rsp_chan holds its response; the next token may be
// accepted meanwhile but cannot finish until the response slot frees.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
   input logic       clock,
   input logic       reset,
   rpn_req_if.sink   req_chan,
   rpn_rsp_if.source rsp_chan
);
   import rpn_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_ADD    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FIX    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]         state_ff, state_in;
   kind_type           kind_ff, kind_in;
   data_type           operand_ff, operand_in;
   status_type         status_ff, status_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   data_type           top_ff, top_in;
   data_type           bottom_ff, bottom_in;
   logic [DATA_W-1:0]  opa_ff, opa_in;
   logic [DATA_W-1:0]  opb_ff, opb_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  result_ff, result_in;
   logic               neg_ff, neg_in;
   logic [4:0]         cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   data_type           rsp_top_ff, rsp_top_in;
   data_type           rsp_bottom_ff, rsp_bottom_in;
   depth_out_type      rsp_depth_ff, rsp_depth_in;
   status_type         rsp_status_ff, rsp_status_in;

   data_type           stack_mem [STACK_DEPTH];
   data_type           rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   data_type           wr_data;

   logic [DATA_W:0]    add_a, add_b;
   logic               add_sub;
   logic [DATA_W+1:0]  add_sum;
   logic               add_ge;

   logic               req_fire;
   logic               rsp_free;
   logic               full;
   data_type           left_val, right_val;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign req_fire              = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_free              = !rsp_valid_ff || rsp_chan.ready;
   assign full                  = (depth_ff >= DEPTH_W'(STACK_DEPTH));
   assign rd_addr               = ADDR_W'(depth_ff - DEPTH_W'(2));
   assign left_val              = rd_data_ff;
   assign right_val             = top_ff;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.top_value    = rsp_top_ff;
   assign rsp_chan.bottom_value = rsp_bottom_ff;
   assign rsp_chan.depth        = rsp_depth_ff;
   assign rsp_chan.status       = rsp_status_ff;

   // shared adder: add/sub, multiply accumulate, divide trial subtract
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         S_ADD: begin
            add_a   = {1'b0, opa_ff};
            add_b   = {1'b0, opb_ff};
            add_sub = (kind_ff == KIND_SUB);
         end
         S_MUL: begin
            add_a = {1'b0, acc_ff};
            add_b = opb_ff[0] ? {1'b0, opa_ff} : '0;
         end
         S_DIV: begin
            add_a   = {acc_ff, opa_ff[DATA_W-1]};
            add_b   = {1'b0, opb_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_a   = '0;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {(DATA_W+1){add_sub}}}
                    + (DATA_W+2)'(add_sub);
   assign add_ge  = add_sum[DATA_W+1];

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      operand_in    = operand_ff;
      status_in     = status_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      bottom_in     = bottom_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      acc_in        = acc_ff;
      result_in     = result_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_top_in    = rsp_top_ff;
      rsp_bottom_in = rsp_bottom_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_addr;
      wr_data       = result_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in    = req_chan.kind;
               operand_in = req_chan.operand;
               status_in  = ST_OK;
               state_in   = S_FINISH;
               if (req_chan.kind == KIND_PUSH) begin
                  if (full) status_in = ST_OVER;
               end else if (req_chan.kind <= KIND_DIV) begin
                  if (depth_ff < DEPTH_W'(2)) begin
                     status_in = ST_UNDER;
                  end else if (req_chan.kind == KIND_DIV && top_ff == '0) begin
                     status_in = ST_DIVZERO;
                  end else begin
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_LOAD: begin
            opa_in = left_val;
            opb_in = right_val;
            acc_in = '0;
            cnt_in = '0;
            neg_in = left_val[DATA_W-1] ^ right_val[DATA_W-1];
            priority if (kind_ff == KIND_MUL) begin
               state_in = S_MUL;
            end else if (kind_ff == KIND_DIV) begin
               opa_in   = left_val[DATA_W-1] ? DATA_W'(-left_val) : left_val;
               opb_in   = right_val[DATA_W-1] ? DATA_W'(-right_val) : right_val;
               state_in = S_DIV;
            end else begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            result_in = add_sum[DATA_W-1:0];
            state_in  = S_FINISH;
         end
         S_MUL: begin
            acc_in    = add_sum[DATA_W-1:0];
            result_in = add_sum[DATA_W-1:0];
            opa_in    = {opa_ff[DATA_W-2:0], 1'b0};
            opb_in    = {1'b0, opb_ff[DATA_W-1:1]};
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_FINISH;
         end
         S_DIV: begin
            acc_in = add_ge ? add_sum[DATA_W-1:0] : add_a[DATA_W-1:0];
            opa_in = {opa_ff[DATA_W-2:0], add_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_FIX;
         end
         S_FIX: begin
            result_in = neg_ff ? DATA_W'(-opa_ff) : opa_ff;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               if (status_ff == ST_OK && kind_ff == KIND_PUSH) begin
                  wr_en    = 1'b1;
                  wr_addr  = ADDR_W'(depth_ff);
                  wr_data  = operand_ff;
                  top_in   = operand_ff;
                  depth_in = depth_ff + DEPTH_W'(1);
                  if (depth_ff == '0) bottom_in = operand_ff;
               end else if (status_ff == ST_OK && kind_ff <= KIND_DIV) begin
                  wr_en    = 1'b1;
                  top_in   = result_ff;
                  depth_in = depth_ff - DEPTH_W'(1);
                  if (depth_ff == DEPTH_W'(2)) bottom_in = result_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (depth_in == '0) ? '0 : top_in;
               rsp_bottom_in = (depth_in == '0) ? '0 : bottom_in;
               rsp_depth_in  = 7'(depth_in);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      operand_ff    <= operand_in;
      status_ff     <= status_in;
      top_ff        <= top_in;
      bottom_ff     <= bottom_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      acc_ff        <= acc_in;
      result_ff     <= result_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   `ASSERT_IMPL(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_W'(STACK_DEPTH))
   `ASSERT_NEXT(a_fire_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   `ASSERT_NEXT(a_depth_only_at_finish, clock, reset, state_ff != S_FINISH, $stable(depth_ff))
   `ASSERT_IMPL(a_finish_fills_slot, clock, reset, state_ff == S_FINISH && rsp_free,
                rsp_valid_in)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RPN stack evaluator: token transactions drive
// a shadow stack that predicts every response, which is then matched
// field by field against the rsp_chan transactions under random idling.
// ----------------------------------------------------------------------------
module tb_top;
   import rpn_pkg::*;

   typedef struct packed {
      data_type      top_value;
      data_type      bottom_value;
      depth_out_type depth;
      status_type    status;
   } stack_view_type;

   class stack_shadow;
      data_type       entries [STACK_DEPTH];
      int             level;
      stack_view_type awaited_views [$];
      int             error_count;

      function new();
         level       = 0;
         error_count = 0;
      endfunction

      function void note_token(kind_type kind, data_type operand);
         stack_view_type view;
         data_type       lhs;
         data_type       rhs;
         data_type       outcome;
         longint         quotient;
         view.status = ST_OK;
         if (kind == KIND_PUSH) begin
            if (level >= STACK_DEPTH) begin
               view.status = ST_OVER;
            end else begin
               entries[level] = operand;
               level++;
            end
         end else if (kind <= KIND_DIV) begin
            if (level < 2) begin
               view.status = ST_UNDER;
            end else begin
               rhs = entries[level-1];
               lhs = entries[level-2];
               if (kind == KIND_DIV && rhs == 0) begin
                  view.status = ST_DIVZERO;
               end else begin
                  case (kind)
                     KIND_ADD: outcome = lhs + rhs;
                     KIND_SUB: outcome = lhs - rhs;
                     KIND_MUL: outcome = lhs * rhs;
                     default: begin
                        quotient = longint'(lhs) / longint'(rhs);
                        outcome  = quotient[DATA_W-1:0];
                     end
                  endcase
                  entries[level-2] = outcome;
                  level--;
               end
            end
         end
         view.top_value    = (level > 0) ? entries[level-1] : '0;
         view.bottom_value = (level > 0) ? entries[0] : '0;
         view.depth        = level[6:0];
         awaited_views.insert(awaited_views.size(), view);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
         end
      endfunction

      function void check_response(data_type top_value, data_type bottom_value,
                                   depth_out_type depth, status_type status);
         stack_view_type view;
         if (awaited_views.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual top %0h depth %0d",
                     $time, top_value, depth);
            error_count++;
            return;
         end
         view = awaited_views.pop_front();
         compare("top_value", view.top_value, top_value);
         compare("bottom_value", view.bottom_value, bottom_value);
         compare("depth", view.depth, depth);
         compare("status", view.status, status);
      endfunction
   endclass

   typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN} walk_mode_type;

   localparam kind_type KIND_NOP_LO     = 3'd5;
   localparam kind_type KIND_NOP_MID    = 3'd6;
   localparam kind_type KIND_NOP_HI     = 3'd7;
   localparam int       ITEMS_PER_PHASE = 240;
   localparam int       CYCLE_LIMIT     = 400000;
   localparam int       DRAIN_CYCLES    = 60;

   localparam data_type MAX_VALUE = 32'sh7fffffff;
   localparam data_type MIN_VALUE = 32'sh80000000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;
   int   cycle_count;

   rpn_req_if req_bus ();
   rpn_rsp_if rsp_bus ();

   stack_shadow shadow = new();

   rpn_stack_evaluator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            shadow.check_response(rsp_bus.top_value, rsp_bus.bottom_value,
                                  rsp_bus.depth, rsp_bus.status);
         end
      end
   end

   task automatic issue_token(kind_type kind, data_type operand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.operand <= operand;
      do @(posedge clock); while (!req_bus.ready);
      shadow.note_token(kind, operand);
   endtask

   function automatic data_type pick_operand();
      int       roll;
      data_type value;
      roll = $urandom_range(99);
      if (roll < 40) begin
         value = $urandom;
      end else if (roll < 65) begin
         value = int'($urandom_range(32)) - 16;
      end else if (roll < 80) begin
         case ($urandom_range(4))
            0: value = 0;
            1: value = 1;
            2: value = -1;
            3: value = MIN_VALUE;
            default: value = MAX_VALUE;
         endcase
      end else begin
         value = $signed($urandom) >>> $urandom_range(31);
      end
      return value;
   endfunction

   task automatic next_token(walk_mode_type mode, output kind_type kind,
                             output data_type operand);
      int roll;
      roll    = $urandom_range(99);
      operand = $urandom;
      case (mode)
         MODE_FILL: begin
            kind    = KIND_PUSH;
            operand = pick_operand();
         end
         MODE_DRAIN: begin
            kind = kind_type'($urandom_range(KIND_ADD, KIND_DIV));
         end
         default: begin
            if (shadow.level < 2 && roll < 90) begin
               kind    = KIND_PUSH;
               operand = pick_operand();
            end else if (shadow.level >= 2 && shadow.entries[shadow.level-1] == 0 &&
                         roll < 30) begin
               kind = KIND_DIV;
            end else if (roll < 45) begin
               kind    = KIND_PUSH;
               operand = pick_operand();
            end else if (roll < 95) begin
               kind = kind_type'($urandom_range(KIND_ADD, KIND_DIV));
            end else begin
               kind = kind_type'($urandom_range(KIND_NOP_LO, KIND_NOP_HI));
            end
         end
      endcase
   endtask

   initial begin : stimulus
      kind_type      kind;
      data_type      operand;
      walk_mode_type mode;
      int            seg_len;
      int            sent;
      int            roll;
      int            guard;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_PUSH;
      req_bus.operand = '0;
      rsp_bus.ready   = 1'b0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_token(KIND_ADD, '0);
      issue_token(KIND_SUB, '0);
      issue_token(KIND_MUL, '0);
      issue_token(KIND_DIV, '0);
      issue_token(KIND_PUSH, MAX_VALUE);
      issue_token(KIND_DIV, '0);
      issue_token(KIND_PUSH, MIN_VALUE);
      issue_token(KIND_ADD, '1);
      issue_token(KIND_PUSH, -1);
      issue_token(KIND_PUSH, 0);
      issue_token(KIND_DIV, '0);
      issue_token(KIND_NOP_LO, '1);
      issue_token(KIND_NOP_MID, MIN_VALUE);
      issue_token(KIND_NOP_HI, MAX_VALUE);
      issue_token(KIND_SUB, '0);
      issue_token(KIND_MUL, '0);
      issue_token(KIND_PUSH, MIN_VALUE);
      issue_token(KIND_PUSH, -1);
      issue_token(KIND_DIV, '0);
      issue_token(KIND_PUSH, 7);
      issue_token(KIND_PUSH, -2);
      issue_token(KIND_DIV, '0);
      issue_token(KIND_SUB, '0);
      issue_token(KIND_PUSH, MAX_VALUE);
      issue_token(KIND_MUL, '0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
               mode    = MODE_FILL;
               seg_len = STACK_DEPTH - shadow.level + $urandom_range(1, 3);
            end else if (roll < 30) begin
               mode    = MODE_DRAIN;
               seg_len = shadow.level + $urandom_range(1, 3);
            end else begin
               mode    = MODE_MIXED;
               seg_len = $urandom_range(10, 40);
            end
            repeat (seg_len) begin
               next_token(mode, kind, operand);
               issue_token(kind, operand);
               sent++;
            end
         end
      end
      req_bus.valid <= 1'b0;

      guard = 0;
      while (shadow.awaited_views.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.awaited_views.size() != 0) begin
         $display("%0t: %0d responses expected, actual none", $time,
                  shadow.awaited_views.size());
         shadow.error_count++;
      end

      if (shadow.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_if.sv
hw/rtl/rpn_stack_evaluator.sv
bench/tb_top.sv
